[hw/rtl/jmsc_pkg.sv]
// ---------------------------------------------------------------------------
// JPEG marker structure check: shared types and constants
// Parse phases, outcome codes, marker codes and the result record that the
// parse core hands to the top level.
// ---------------------------------------------------------------------------
package jmsc_pkg;

  // Width of the reported image length.
  localparam int unsigned ImgLenW = 19;

  // Marker codes.
  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkDht    = 8'hC4;
  localparam logic [7:0] MarkApp1   = 8'hE1;
  localparam logic [7:0] MarkRst0   = 8'hD0;
  localparam logic [7:0] MarkStuff  = 8'h00;

  // DHT header: class byte plus sixteen code counts.
  localparam logic [4:0]  DhtHdrBytes = 5'd17;
  // Smallest DHT length that holds the header (length field plus header).
  localparam logic [15:0] DhtMinLen   = 16'd19;
  localparam logic [15:0] LenFieldBytes = 16'd2;

  // Parse phase of the marker walk.
  typedef enum logic [2:0] {
    PH_SOI0  = 3'd0,
    PH_SOI1  = 3'd1,
    PH_MARK  = 3'd2,
    PH_CODE  = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  // Verdict codes.
  typedef enum logic [2:0] {
    OUT_EOI        = 3'd0,
    OUT_SCAN_DATA  = 3'd1,
    OUT_END_SOS    = 3'd2,
    OUT_NO_SOI     = 3'd3,
    OUT_EXP_MARKER = 3'd4,
    OUT_BAD_LEN    = 3'd5,
    OUT_END_NO_SOS = 3'd6
  } outcome_e;

  // One verdict.
  typedef struct packed {
    logic                 is_valid;
    outcome_e             outcome;
    logic [ImgLenW-1:0]   image_length;
    logic                 saw_app1;
    logic [7:0]           error_total;
  } jmsc_res_t;

endpackage

[hw/rtl/jmsc_core.sv]
// ---------------------------------------------------------------------------
// JPEG marker structure check: parse core
// Holds the marker walk state and steps it by one byte per transfer. Gives at
// most one verdict per byte, in the same cycle as the step.
// ---------------------------------------------------------------------------
module jmsc_core #(
  parameter int unsigned MAX_BYTES = 262144
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic                last_byte_i,
  output logic                res_vld_o,
  output jmsc_pkg::jmsc_res_t res_o
);
  import jmsc_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_BYTES + 1);
  localparam int unsigned ExtW = (PosW + 1 > ImgLenW) ? PosW + 1 : ImgLenW;
  localparam logic [PosW:0] MaxPos = (PosW + 1)'(MAX_BYTES);

  // State registers.
  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       marker_q, marker_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [15:0]      seg_len_q, seg_len_d;
  logic [15:0]      skip_q, skip_d;
  logic [4:0]       idx_q, idx_d;
  logic [11:0]      total_q, total_d;
  logic             scan_q, scan_d;
  logic             app1_q, app1_d;
  logic [7:0]       tally_q, tally_d;
  logic             verdict_q, verdict_d;

  // State as seen by this byte (a first byte starts from the reset state).
  phase_e           phase_c;
  logic [PosW-1:0]  pos_c;
  logic [7:0]       marker_c, len_hi_c;
  logic [15:0]      seg_len_c, skip_c;
  logic [4:0]       idx_c;
  logic [11:0]      total_c;
  logic             scan_c, app1_c, verdict_c;
  logic [7:0]       tally_c;

  logic [PosW:0]    pos_inc;
  logic [ExtW-1:0]  pos_ext;
  logic [15:0]      seg_new;
  logic [15:0]      skip_dec;
  logic [4:0]       idx_inc;
  logic [11:0]      total_add;
  logic             bump;
  logic             emit;

  always_comb begin
    if (first_byte_i) begin
      phase_c   = PH_SOI0;
      pos_c     = '0;
      marker_c  = '0;
      len_hi_c  = '0;
      seg_len_c = '0;
      skip_c    = '0;
      idx_c     = '0;
      total_c   = '0;
      scan_c    = 1'b0;
      app1_c    = 1'b0;
      tally_c   = '0;
      verdict_c = 1'b0;
    end else begin
      phase_c   = phase_q;
      pos_c     = pos_q;
      marker_c  = marker_q;
      len_hi_c  = len_hi_q;
      seg_len_c = seg_len_q;
      skip_c    = skip_q;
      idx_c     = idx_q;
      total_c   = total_q;
      scan_c    = scan_q;
      app1_c    = app1_q;
      tally_c   = tally_q;
      verdict_c = verdict_q;
    end
  end

  assign pos_inc   = {1'b0, pos_c} + {{PosW{1'b0}}, 1'b1};
  assign pos_ext   = ExtW'(pos_inc);
  assign seg_new   = {len_hi_c, data_byte_i};
  assign skip_dec  = skip_c - 16'd1;
  assign idx_inc   = idx_c + 5'd1;
  assign total_add = total_c + ((idx_c != 5'd0) ? {4'd0, data_byte_i} : 12'd0);

  // One byte of the marker walk.
  always_comb begin
    phase_d   = phase_c;
    pos_d     = pos_c;
    marker_d  = marker_c;
    len_hi_d  = len_hi_c;
    seg_len_d = seg_len_c;
    skip_d    = skip_c;
    idx_d     = idx_c;
    total_d   = total_c;
    scan_d    = scan_c;
    app1_d    = app1_c;
    bump      = 1'b0;
    emit      = 1'b0;
    res_o.is_valid     = 1'b0;
    res_o.outcome      = OUT_EOI;
    res_o.image_length = '0;

    if (!verdict_c) begin
      case (phase_c)
        PH_SOI0: begin
          if (data_byte_i != MarkPrefix) begin
            emit          = 1'b1;
            res_o.outcome = OUT_NO_SOI;
          end else begin
            phase_d = PH_SOI1;
          end
        end
        PH_SOI1: begin
          if (data_byte_i != MarkSoi) begin
            emit          = 1'b1;
            res_o.outcome = OUT_NO_SOI;
          end else begin
            phase_d = PH_MARK;
          end
        end
        PH_MARK: begin
          if (data_byte_i != MarkPrefix) begin
            emit           = 1'b1;
            res_o.is_valid = scan_c;
            res_o.outcome  = scan_c ? OUT_SCAN_DATA : OUT_EXP_MARKER;
          end else begin
            phase_d = PH_CODE;
          end
        end
        PH_CODE: begin
          if (data_byte_i == MarkPrefix) begin
            // Fill byte: the next byte is again a marker code.
            phase_d = PH_CODE;
          end else if (data_byte_i == MarkEoi) begin
            emit               = 1'b1;
            res_o.is_valid     = 1'b1;
            res_o.outcome      = OUT_EOI;
            res_o.image_length = pos_ext[ImgLenW-1:0];
          end else if (data_byte_i inside {[MarkRst0:MarkSoi], MarkStuff}) begin
            // Standalone marker without a length.
            phase_d = PH_MARK;
          end else begin
            marker_d = data_byte_i;
            phase_d  = PH_LENHI;
          end
        end
        PH_LENHI: begin
          len_hi_d = data_byte_i;
          phase_d  = PH_LENLO;
        end
        PH_LENLO: begin
          seg_len_d = seg_new;
          if (seg_new < LenFieldBytes) begin
            bump          = 1'b1;
            emit          = 1'b1;
            res_o.outcome = OUT_BAD_LEN;
          end else begin
            if (marker_c == MarkSos) begin
              scan_d = 1'b1;
            end
            if (marker_c == MarkApp1) begin
              app1_d = 1'b1;
            end
            idx_d   = '0;
            total_d = '0;
            // A DHT too short to hold its header counts its error here.
            if (marker_c == MarkDht && seg_new < DhtMinLen) begin
              bump = 1'b1;
            end
            skip_d  = seg_new - LenFieldBytes;
            phase_d = (seg_new == LenFieldBytes) ? PH_MARK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          // Sum the DHT code counts that follow the class byte.
          if (marker_c == MarkDht && seg_len_c >= DhtMinLen && idx_c < DhtHdrBytes) begin
            total_d = total_add;
            idx_d   = idx_inc;
            if (idx_inc == DhtHdrBytes &&
                (DhtMinLen + {4'd0, total_add}) > seg_len_c) begin
              bump = 1'b1;
            end
          end
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = PH_MARK;
          end
        end
        default: begin
          phase_d = PH_MARK;
        end
      endcase

      if (!emit) begin
        if ({1'b0, pos_c} < MaxPos) begin
          pos_d = pos_inc[PosW-1:0];
        end
        // End of the buffer: verdict from the phase this byte moves the walk to.
        if (last_byte_i || pos_inc >= MaxPos) begin
          emit = 1'b1;
          if (phase_d == PH_SOI0 || phase_d == PH_SOI1) begin
            res_o.outcome = OUT_NO_SOI;
          end else begin
            res_o.is_valid = scan_d;
            res_o.outcome  = scan_d ? OUT_END_SOS : OUT_END_NO_SOS;
          end
        end
      end
    end

    // Saturating error tally.
    tally_d = (bump && tally_c != 8'hFF) ? tally_c + 8'd1 : tally_c;
    verdict_d = verdict_c | emit;
    res_o.saw_app1    = app1_d;
    res_o.error_total = tally_d;
  end

  assign res_vld_o = step_i & emit;

  // Walk state, updated on every processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SOI0;
      pos_q     <= '0;
      marker_q  <= '0;
      len_hi_q  <= '0;
      seg_len_q <= '0;
      skip_q    <= '0;
      idx_q     <= '0;
      total_q   <= '0;
      scan_q    <= 1'b0;
      app1_q    <= 1'b0;
      tally_q   <= '0;
      verdict_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      marker_q  <= marker_d;
      len_hi_q  <= len_hi_d;
      seg_len_q <= seg_len_d;
      skip_q    <= skip_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      scan_q    <= scan_d;
      app1_q    <= app1_d;
      tally_q   <= tally_d;
      verdict_q <= verdict_d;
    end
  end

endmodule

[hw/rtl/jpeg_marker_structure_check.sv]
// ---------------------------------------------------------------------------
// JPEG marker structure check
// Walks the marker chain of a candidate image one byte per transfer and gives
// one verdict per candidate.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake                 payload
//   input     in          in_valid_i / in_ready_o   data_byte_i, first_byte_i,
//                                                   last_byte_i
//   result    out         out_valid_o / out_ready_i is_valid_o, outcome_o,
//                                                   image_length_o, saw_app1_o,
//                                                   error_total_o
//
// One byte per cycle while the result queue has room. A byte is held in the
// input register, stepped through the parse core, and its verdict, if any, is
// written to a two-entry result queue; input stalls only while it is full.
// Reset clears the walk state; the first byte after reset is taken as byte 0.
// ---------------------------------------------------------------------------
module jpeg_marker_structure_check #(
  parameter int unsigned MAX_BYTES = 262144
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        first_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_valid_o,
  output logic [2:0]                  outcome_o,
  output logic [jmsc_pkg::ImgLenW-1:0] image_length_o,
  output logic                        saw_app1_o,
  output logic [7:0]                  error_total_o
);
  import jmsc_pkg::*;

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] data_q;
  logic       first_q;
  logic       last_q;
  logic       step;

  // Result queue.
  jmsc_res_t  q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  logic       res_vld;
  jmsc_res_t  res;

  assign step       = in_vld_q && (cnt_q != 2'd2);
  assign in_ready_o = !in_vld_q || step;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
  end

  // Marker walk.
  jmsc_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (data_q),
    .first_byte_i (first_q),
    .last_byte_i  (last_q),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  // Result queue bookkeeping.
  assign push  = res_vld;
  assign pop   = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= res;
    end
  end

  // Result ports.
  assign out_valid_o    = (cnt_q != 2'd0);
  assign is_valid_o     = q_mem[rd_q].is_valid;
  assign outcome_o      = q_mem[rd_q].outcome;
  assign image_length_o = q_mem[rd_q].image_length;
  assign saw_app1_o     = q_mem[rd_q].saw_app1;
  assign error_total_o  = q_mem[rd_q].error_total;

  // The queue never holds more than two verdicts.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  // No byte is stepped while the queue is full.
  a_no_step_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !step)
    else $error("byte stepped with a full result queue");

  // The valid flag agrees with the outcome code.
  a_valid_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_valid_o == (outcome_o == OUT_EOI ||
                                    outcome_o == OUT_SCAN_DATA ||
                                    outcome_o == OUT_END_SOS)))
    else $error("valid flag disagrees with outcome");

  // Only an EOI verdict carries an image length.
  a_len_eoi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o != OUT_EOI) |-> image_length_o == '0)
    else $error("image length on a verdict other than EOI");

endmodule
